FILE: hdl/alaw_gain_upsample_defines.svh
// Assertion macros shared by the alaw_gain_upsample RTL.
// Included by the modules that carry concurrent assertions; no dependencies.
`ifndef ALAW_GAIN_UPSAMPLE_DEFINES_SVH
`define ALAW_GAIN_UPSAMPLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define ALAWGU_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ALAWGU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/alawgu_pkg.sv
// Shared types, constants and the A-law expander for alaw_gain_upsample.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package alawgu_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_Q15      = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OVERSAMPLE_ON = 8'd1;

    // Gain format and limits (Q15, clamped to plus or minus 8.0)
    localparam int GAIN_W = 20;
    localparam logic signed [GAIN_W-1:0] GAIN_MAX   = 20'sd262144;
    localparam logic signed [GAIN_W-1:0] GAIN_MIN   = -20'sd262144;
    localparam logic signed [GAIN_W-1:0] GAIN_RESET = 20'sd4096;

    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = SAMPLE_W + GAIN_W;
    localparam logic [SAMPLE_W-1:0] DAC_OFFSET = 16'h8000;

    // Default depth of the queue between front and back
    localparam int FIFO_DEPTH_DEF = 4;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                pend;
    } sample_entry_t;

    // Expand one A-law byte to signed linear (magnitude at most 32256)
    function automatic logic signed [SAMPLE_W-1:0] alaw_expand(input logic [7:0] code);
        logic [7:0]          a;
        logic [2:0]          seg;
        logic [SAMPLE_W-1:0] mag;
        begin
            a   = code ^ 8'h55;
            seg = a[6:4];
            mag = {8'b0, a[3:0], 4'b0};
            if (seg == 3'd0) begin
                mag = mag + 16'd8;
            end else begin
                mag = (mag + 16'h0108) << (seg - 3'd1);
            end
            alaw_expand = a[7] ? $signed(mag) : -$signed(mag);
        end
    endfunction

endpackage

FILE: hdl/alawgu_fifo.sv
// Short queue of scaled samples between the front and the back.
// Depends on alawgu_pkg and alaw_gain_upsample_defines.svh.
`timescale 1ns / 1ps
`include "alaw_gain_upsample_defines.svh"

module alawgu_fifo #(
    parameter int DEPTH = alawgu_pkg::FIFO_DEPTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  alawgu_pkg::sample_entry_t push_data,
    output logic                      full,
    input  logic                      pop,
    output alawgu_pkg::sample_entry_t pop_data,
    output logic                      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    alawgu_pkg::sample_entry_t slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slots_reg[rd_ptr_reg];

    // Advance pointers with wrap at the queue depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ALAWGU_ASSERT_NOW(a_fifo_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH), "queue count exceeds depth")
    `ALAWGU_ASSERT_NEXT(a_fifo_fill, aclk, aresetn, do_push && !do_pop, !empty, "queue empty after a lone push")

endmodule

FILE: hdl/alawgu_front.sv
// Front part: accepts A-law bytes, expands, scales by the gain, saturates and offsets.
// Depends on alawgu_pkg; feeds alawgu_fifo.
`timescale 1ns / 1ps

module alawgu_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic signed [alawgu_pkg::GAIN_W-1:0]  gain_q15,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [7:0]                            s_alaw_code,
    input  logic                                  s_packet_end,
    output logic                                  push,
    output alawgu_pkg::sample_entry_t             push_data,
    input  logic                                  push_full
);

    localparam int SW = alawgu_pkg::SAMPLE_W;
    localparam int PW = alawgu_pkg::PROD_W;
    localparam int SHW = PW - 15;

    logic                 lin_valid_reg;
    logic signed [SW-1:0] lin_reg;
    logic                 lin_pend_reg;
    logic                 prod_valid_reg;
    logic signed [PW-1:0] prod_reg;
    logic                 prod_pend_reg;
    logic                 adv_lin, adv_prod;
    logic signed [SHW-1:0] shifted;
    logic signed [SW-1:0]  sat;

    // Each stage moves when the one after it can take its contents
    assign adv_prod = !prod_valid_reg || !push_full;
    assign adv_lin  = !lin_valid_reg || adv_prod;
    assign s_ready  = adv_lin;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lin_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
        end else begin
            if (adv_lin) begin
                lin_valid_reg <= s_valid;
            end
            if (adv_prod) begin
                prod_valid_reg <= lin_valid_reg;
            end
        end
    end

    // Expand the byte, then multiply by the gain
    always_ff @(posedge aclk) begin
        if (adv_lin && s_valid) begin
            lin_reg      <= alawgu_pkg::alaw_expand(s_alaw_code);
            lin_pend_reg <= s_packet_end;
        end
        if (adv_prod && lin_valid_reg) begin
            prod_reg      <= PW'(lin_reg) * PW'(gain_q15);
            prod_pend_reg <= lin_pend_reg;
        end
    end

    // Arithmetic shift by 15 (floor), saturate to 16 bits, then offset
    assign shifted = prod_reg[PW-1:15];

    always_comb begin
        if (shifted > SHW'(32767)) begin
            sat = 16'sh7FFF;
        end else if (shifted < -SHW'(32768)) begin
            sat = -16'sh8000;
        end else begin
            sat = shifted[SW-1:0];
        end
    end

    assign push             = prod_valid_reg;
    assign push_data.sample = $unsigned(sat) + alawgu_pkg::DAC_OFFSET;
    assign push_data.pend   = prod_pend_reg;

endmodule

FILE: hdl/alawgu_back.sv
// Back part: keeps the sample history, forms the midpoint and drives results.
// Depends on alawgu_pkg and alaw_gain_upsample_defines.svh.
`timescale 1ns / 1ps
`include "alaw_gain_upsample_defines.svh"

module alawgu_back (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  oversample_on,
    input  logic                                  head_empty,
    input  alawgu_pkg::sample_entry_t             head,
    output logic                                  pop,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [alawgu_pkg::SAMPLE_W-1:0]       m_dac_sample,
    output logic                                  m_last_of_pair,
    output logic                                  m_ends_packet
);

    localparam int SW = alawgu_pkg::SAMPLE_W;
    localparam int NW = SW + 5;

    logic [SW-1:0] oldest_reg, middle_reg, newest_reg;
    logic          out_valid_reg;
    logic [SW-1:0] out_sample_reg;
    logic          out_last_reg, out_end_reg;
    logic          hold_valid_reg;
    logic [SW-1:0] hold_sample_reg;
    logic          hold_pend_reg;
    logic          out_free, take;
    logic [NW-1:0] six_mid, three_new;
    logic signed [NW-1:0] num;
    logic [SW-1:0] mid;

    assign out_free = !out_valid_reg || m_ready;
    assign take     = out_free && !hold_valid_reg && !head_empty;
    assign pop      = take;

    // Midpoint from the history as it stands after this item shifts in
    assign six_mid   = {3'b0, newest_reg, 2'b0} + {4'b0, newest_reg, 1'b0};
    assign three_new = {4'b0, head.sample, 1'b0} + {5'b0, head.sample};
    assign num       = $signed(six_mid + three_new - {5'b0, middle_reg});

    // Truncate toward zero and clamp to the DAC range
    always_comb begin
        if (num[NW-1]) begin
            mid = '0;
        end else if (num[NW-2:SW+3] != '0) begin
            mid = '1;
        end else begin
            mid = num[SW+2:3];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oldest_reg     <= '0;
            middle_reg     <= '0;
            newest_reg     <= '0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            if (out_free) begin
                if (hold_valid_reg) begin
                    // Release the held sample as the final transaction
                    out_valid_reg  <= 1'b1;
                    hold_valid_reg <= 1'b0;
                end else if (!head_empty) begin
                    out_valid_reg  <= 1'b1;
                    hold_valid_reg <= oversample_on;
                end else begin
                    out_valid_reg <= 1'b0;
                end
            end
            // Shift the history on every item taken
            if (take) begin
                oldest_reg <= middle_reg;
                middle_reg <= newest_reg;
                newest_reg <= head.sample;
            end
        end
    end

    // Result payload and the held sample
    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (hold_valid_reg) begin
                out_sample_reg <= hold_sample_reg;
                out_last_reg   <= 1'b1;
                out_end_reg    <= hold_pend_reg;
            end else if (!head_empty) begin
                if (oversample_on) begin
                    out_sample_reg <= mid;
                    out_last_reg   <= 1'b0;
                    out_end_reg    <= 1'b0;
                end else begin
                    out_sample_reg <= head.sample;
                    out_last_reg   <= 1'b1;
                    out_end_reg    <= head.pend;
                end
            end
        end
        if (take) begin
            hold_sample_reg <= head.sample;
            hold_pend_reg   <= head.pend;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_dac_sample   = out_sample_reg;
    assign m_last_of_pair = out_last_reg;
    assign m_ends_packet  = out_end_reg;

    `ALAWGU_ASSERT_NOW(a_hold_needs_out, aclk, aresetn, hold_valid_reg, out_valid_reg, "held sample without a midpoint in the output register")
    `ALAWGU_ASSERT_NEXT(a_mid_then_final, aclk, aresetn, out_valid_reg && !out_last_reg && m_ready, out_valid_reg && out_last_reg, "midpoint not followed by its sample")
    `ALAWGU_ASSERT_NOW(a_end_on_final, aclk, aresetn, out_valid_reg && out_end_reg, out_last_reg, "packet end flagged on a midpoint")
    `ALAWGU_ASSERT_NOW(a_no_pop_while_held, aclk, aresetn, hold_valid_reg, !pop, "queue popped while a sample is held")

endmodule

FILE: hdl/alaw_gain_upsample.sv
// Top level of the A-law decoder with gain and 2x quadratic interpolation.
// Depends on alawgu_pkg, alawgu_front, alawgu_fifo and alawgu_back.
//
// Usage:
//   s_ channel: one A-law byte (s_alaw_code) and a packet marker
//   (s_packet_end) per transaction, valid/ready handshake.
//   m_ channel: offset-binary DAC samples (32768 is silence). With
//   oversampling on, each byte gives a midpoint (m_last_of_pair low) and
//   then its sample (m_last_of_pair high, m_ends_packet copied from input).
//   cfg_ channel: index 0 writes the Q15 gain (clamped to plus or minus
//   8.0), index 1 the oversample enable; other indexes are ignored.
//   cfg_ready is always high; write only while the block is idle.
// Path: the input transaction loads the expand register, then the multiply
//   register, then a queue slot, then the output register that drives m_valid.
// Throughput: one byte per cycle with oversampling off while m_ready is high;
//   with it on, each byte leaves as two transactions through the single output
//   register of the back part, which takes no new byte until the held one is out.
// Reset: aresetn low for one clock clears history to zero, gain to 0.125,
//   oversampling on, and empties the pipeline. When the receiver stalls,
//   the output register holds, the queue fills, then s_ready drops.
`timescale 1ns / 1ps

module alaw_gain_upsample #(
    parameter int FIFO_DEPTH = alawgu_pkg::FIFO_DEPTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [7:0]                             s_alaw_code,
    input  logic                                   s_packet_end,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [alawgu_pkg::SAMPLE_W-1:0]        m_dac_sample,
    output logic                                   m_last_of_pair,
    output logic                                   m_ends_packet,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [alawgu_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic signed [alawgu_pkg::GAIN_W-1:0]   cfg_data
);

    logic signed [alawgu_pkg::GAIN_W-1:0] gain_reg;
    logic                                 oversample_reg;
    logic                                 push, full, pop, empty;
    alawgu_pkg::sample_entry_t            push_data, pop_data;

    assign cfg_ready = 1'b1;

    // Take register writes, clamping the gain to its bounds
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg       <= alawgu_pkg::GAIN_RESET;
            oversample_reg <= 1'b1;
        end else if (cfg_valid) begin
            if (cfg_index == alawgu_pkg::CFG_GAIN_Q15) begin
                if (cfg_data > alawgu_pkg::GAIN_MAX) begin
                    gain_reg <= alawgu_pkg::GAIN_MAX;
                end else if (cfg_data < alawgu_pkg::GAIN_MIN) begin
                    gain_reg <= alawgu_pkg::GAIN_MIN;
                end else begin
                    gain_reg <= cfg_data;
                end
            end else if (cfg_index == alawgu_pkg::CFG_OVERSAMPLE_ON) begin
                oversample_reg <= cfg_data[0];
            end
        end
    end

    alawgu_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .gain_q15     (gain_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_alaw_code  (s_alaw_code),
        .s_packet_end (s_packet_end),
        .push         (push),
        .push_data    (push_data),
        .push_full    (full)
    );

    alawgu_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    alawgu_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .oversample_on  (oversample_reg),
        .head_empty     (empty),
        .head           (pop_data),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_dac_sample   (m_dac_sample),
        .m_last_of_pair (m_last_of_pair),
        .m_ends_packet  (m_ends_packet)
    );

endmodule
